// File: rtl/lru_slot_list_manager_macros.svh
// Assertion macros used by the sequencer of the slot list manager RTL.
`ifndef LRU_SLOT_LIST_MANAGER_MACROS_SVH
`define LRU_SLOT_LIST_MANAGER_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define LSM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Check that a condition in one cycle leads to another in the next cycle.
`define LSM_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lsm_pkg.sv
// Shared constants and types of the slot list manager.
`default_nettype none
package lsm_pkg;

    localparam int unsigned SLOTS_DEF = 1024;

    typedef struct packed {
        logic rejected;
        logic reused;
    } lsm_flags_t;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_TOUCH = 1'b1;

endpackage
`default_nettype wire

// File: rtl/lsm_link_ram.sv
// Link memory: one write port and one registered read port.
`default_nettype none
module lsm_link_ram #(
    parameter int unsigned DEPTH = lsm_pkg::SLOTS_DEF,
    parameter int unsigned WIDTH = $clog2(lsm_pkg::SLOTS_DEF)
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

// File: rtl/lsm_seq.sv
// Sequencer: decodes an item and steps the link writes through the two ring memories.
`default_nettype none
`include "lru_slot_list_manager_macros.svh"
module lsm_seq #(
    parameter int unsigned SLOTS = lsm_pkg::SLOTS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     in_op,
    input  wire logic [$clog2(SLOTS)-1:0] in_slot,
    output logic                          res_valid,
    input  wire logic                     res_ready,
    output logic      [$clog2(SLOTS)-1:0] res_slot,
    output lsm_pkg::lsm_flags_t           res_flags
);
    localparam int unsigned SLOT_W = $clog2(SLOTS);
    localparam int unsigned CNT_W  = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_W1   = 3'd1;
    localparam logic [2:0] ST_W2   = 3'd2;
    localparam logic [2:0] ST_W3   = 3'd3;
    localparam logic [2:0] ST_FIN  = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [SLOT_W-1:0] newest_reg, newest_next;
    logic [SLOT_W-1:0] oldest_reg, oldest_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              op_reg, op_next;
    lsm_pkg::lsm_flags_t flags_reg, flags_next;

    // toward_older memory (om) and toward_newer memory (nm)
    logic              om_we, nm_we;
    logic [SLOT_W-1:0] om_waddr, om_wdata, nm_waddr, nm_wdata;
    logic [SLOT_W-1:0] om_rdata, nm_rdata;
    logic              accept;
    logic              full;
    logic              reject;

    assign accept   = in_valid && in_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign full     = (used_reg == CNT_W'(SLOTS));
    assign reject   = ({{(CNT_W - SLOT_W){1'b0}}, in_slot} >= used_reg);

    lsm_link_ram #(.DEPTH(SLOTS), .WIDTH(SLOT_W)) u_older (
        .aclk   (aclk),
        .wr_en  (om_we),
        .wr_addr(om_waddr),
        .wr_data(om_wdata),
        .rd_en  (accept),
        .rd_addr(in_slot),
        .rd_data(om_rdata)
    );

    lsm_link_ram #(.DEPTH(SLOTS), .WIDTH(SLOT_W)) u_newer (
        .aclk   (aclk),
        .wr_en  (nm_we),
        .wr_addr(nm_waddr),
        .wr_data(nm_wdata),
        .rd_en  (accept),
        .rd_addr(in_slot),
        .rd_data(nm_rdata)
    );

    always_comb begin
        om_we    = 1'b0;
        nm_we    = 1'b0;
        om_waddr = slot_reg;
        om_wdata = newest_reg;
        nm_waddr = slot_reg;
        nm_wdata = oldest_reg;
        unique case (state_reg)
            ST_W1: begin
                // unlink the touched slot from its neighbors
                om_we    = 1'b1;
                om_waddr = nm_rdata;
                om_wdata = om_rdata;
                nm_we    = 1'b1;
                nm_waddr = om_rdata;
                nm_wdata = nm_rdata;
            end
            ST_W2: begin
                om_we = 1'b1;
                nm_we = 1'b1;
            end
            ST_W3: begin
                // close the ring between newest and oldest through the slot
                om_we    = 1'b1;
                om_waddr = oldest_reg;
                om_wdata = slot_reg;
                nm_we    = 1'b1;
                nm_waddr = newest_reg;
                nm_wdata = slot_reg;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        used_next   = used_reg;
        newest_next = newest_reg;
        oldest_next = oldest_reg;
        slot_next   = slot_reg;
        op_next     = op_reg;
        flags_next  = flags_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    op_next    = in_op;
                    flags_next = '0;
                    state_next = ST_FIN;
                    if (in_op == lsm_pkg::OP_ALLOC) begin
                        if (full) begin
                            slot_next         = oldest_reg;
                            flags_next.reused = 1'b1;
                        end else begin
                            slot_next  = used_reg[SLOT_W-1:0];
                            state_next = ST_W2;
                        end
                    end else begin
                        slot_next = in_slot;
                        if (reject) begin
                            flags_next.rejected = 1'b1;
                        end else if (in_slot != newest_reg) begin
                            state_next = ST_W1;
                        end
                    end
                end
            end
            ST_W1: begin
                if (slot_reg == oldest_reg) begin
                    oldest_next = nm_rdata;
                end
                state_next = ST_W2;
            end
            ST_W2: begin
                state_next = ST_W3;
            end
            ST_W3: begin
                if (op_reg == lsm_pkg::OP_ALLOC) begin
                    oldest_next = slot_reg;
                    used_next   = used_reg + CNT_W'(1);
                end else begin
                    newest_next = slot_reg;
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                if (res_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            used_reg   <= '0;
            newest_reg <= '0;
            oldest_reg <= '0;
        end else begin
            state_reg  <= state_next;
            used_reg   <= used_next;
            newest_reg <= newest_next;
            oldest_reg <= oldest_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg  <= slot_next;
        op_reg    <= op_next;
        flags_reg <= flags_next;
    end

    assign res_valid = (state_reg == ST_FIN);
    assign res_slot  = slot_reg;
    assign res_flags = flags_reg;

    `LSM_ASSERT(a_used_bound, aclk, aresetn, used_reg <= CNT_W'(SLOTS), "slot count over capacity")
    `LSM_ASSERT(a_newest_in_use, aclk, aresetn,
        (used_reg == '0) || ({{(CNT_W - SLOT_W){1'b0}}, newest_reg} < used_reg),
        "newest slot not handed out")
    `LSM_ASSERT(a_oldest_in_use, aclk, aresetn,
        (used_reg == '0) || ({{(CNT_W - SLOT_W){1'b0}}, oldest_reg} < used_reg),
        "oldest slot not handed out")
    `LSM_ASSERT_NEXT(a_accept_busy, aclk, aresetn, accept, state_reg != ST_IDLE,
        "accepted item left sequencer idle")
    `LSM_ASSERT_NEXT(a_used_step, aclk, aresetn, state_reg == ST_IDLE,
        (used_reg == $past(used_reg)) || (used_reg == $past(used_reg) + CNT_W'(1)),
        "slot count jumped")
endmodule
`default_nettype wire

// File: rtl/lru_slot_list_manager.sv
// Each item passes W1, W2 and W3 for a touch of a non-newest slot, W2 and W3 for an
// allocate of a fresh slot, and straight to FIN otherwise; one item in the sequencer
// at a time. The pace is set by these write steps through the single write port of
// each ring memory. A result blocked by a full output register holds the FSM in FIN.
// Reset (aresetn low, synchronous) empties the pool and drops any pending result;
// the ring memories are not cleared, since every link is written before it is read.
`default_nettype none
module lru_slot_list_manager #(
    parameter int unsigned SLOTS = lsm_pkg::SLOTS_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // [0] opcode, [SLOT_W:1] slot_in, rest zero
    input  wire logic [((1 + $clog2(SLOTS) + 7) / 8) * 8 - 1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // [SLOT_W-1:0] slot_out, rest zero
    output logic      [(($clog2(SLOTS) + 7) / 8) * 8 - 1:0] m_tdata,
    // [0] reused, [1] rejected
    output logic      [1:0] m_tuser
);
    localparam int unsigned SLOT_W = $clog2(SLOTS);
    localparam int unsigned OUT_W  = ((SLOT_W + 7) / 8) * 8;

    logic                res_valid;
    logic                res_ready;
    logic [SLOT_W-1:0]   res_slot;
    lsm_pkg::lsm_flags_t res_flags;
    logic                out_valid_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    lsm_pkg::lsm_flags_t out_flags_reg;

    lsm_seq #(.SLOTS(SLOTS)) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_op    (s_tdata[0]),
        .in_slot  (s_tdata[SLOT_W:1]),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res_slot (res_slot),
        .res_flags(res_flags)
    );

    // take a new result once the held one is gone or leaves this cycle
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_slot_reg  <= res_slot;
            out_flags_reg <= res_flags;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_W'(out_slot_reg);
    assign m_tuser  = {out_flags_reg.rejected, out_flags_reg.reused};
endmodule
`default_nettype wire

// File: sim/tb_lru_slot_list_manager.sv
// Self-checking testbench for the LRU slot list manager: ring prediction, directed and random items.
`timescale 1ns / 100ps
module tb_lru_slot_list_manager;

    localparam int unsigned SLOTS = lsm_pkg::SLOTS_DEF;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int S_W = ((1 + SLOT_W + 7) / 8) * 8;
    localparam int M_W = ((SLOT_W + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 12;

    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        slot_t slot;
        logic  reused;
        logic  rejected;
    } slot_result_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic [1:0]     m_tuser;

    // predicted recency ring
    slot_t       ring_newer [SLOTS];
    slot_t       ring_older [SLOTS];
    slot_t       ring_newest = '0;
    int unsigned ring_count = 0;

    slot_result_t pending_results[$];

    int mismatch_count = 0;
    int items_sent = 0;
    int results_seen = 0;
    int reuse_count = 0;
    int reject_count = 0;
    int burst_left = 0;
    int stall_left = 0;
    int cycle_count = 0;

    lru_slot_list_manager #(.SLOTS(SLOTS)) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // [0] opcode, [SLOT_W:1] slot_in, rest zero
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // [SLOT_W-1:0] slot_out, rest zero
        .m_tuser (m_tuser)    // [0] reused, [1] rejected
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_results.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Put slot s between the newest slot and the oldest one, so it becomes the oldest.
    function automatic void splice_behind_newest(input slot_t s);
        slot_t oldest;
        oldest = ring_newer[ring_newest];
        ring_newer[s] = oldest;
        ring_older[s] = ring_newest;
        ring_older[oldest] = s;
        ring_newer[ring_newest] = s;
    endfunction

    function automatic slot_result_t predict_ring_result(input logic op, input slot_t slot);
        slot_result_t r;
        slot_t fresh;
        slot_t older_nb;
        slot_t newer_nb;
        r = '0;
        if (op == lsm_pkg::OP_ALLOC) begin
            if (ring_count < SLOTS) begin
                fresh = slot_t'(ring_count);
                if (ring_count == 0) begin
                    ring_newer[fresh] = fresh;
                    ring_older[fresh] = fresh;
                    ring_newest = fresh;
                end else begin
                    splice_behind_newest(fresh);
                end
                ring_count++;
                r.slot = fresh;
            end else begin
                r.slot = ring_newer[ring_newest];
                r.reused = 1'b1;
            end
        end else begin
            r.slot = slot;
            if (slot >= ring_count) begin
                r.rejected = 1'b1;
            end else if (slot != ring_newest) begin
                older_nb = ring_older[slot];
                newer_nb = ring_newer[slot];
                ring_older[newer_nb] = older_nb;
                ring_newer[older_nb] = newer_nb;
                splice_behind_newest(slot);
                ring_newest = slot;
            end
        end
        return r;
    endfunction

    task automatic send_item(input logic op, input slot_t slot);
        logic [S_W-1:0] word;
        word = '0;
        word[0] = op;
        word[SLOT_W:1] = slot;
        s_tvalid <= 1'b1;
        s_tdata <= word;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_results.push_back(predict_ring_result(op, slot));
        items_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = $urandom_range(0, 19);
        end
    endtask

    task automatic wait_all_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        burst_left = $urandom_range(0, 19);
    endtask

    // Bias toward the ring ends, where link updates wrap.
    function automatic slot_t pick_handed_out_slot();
        if (ring_count == 0)
            return slot_t'($urandom_range(0, SLOTS - 1));
        case ($urandom_range(0, 7))
            0: return ring_newest;
            1: return ring_newer[ring_newest];
            default: return slot_t'($urandom_range(0, ring_count - 1));
        endcase
    endfunction

    task automatic send_random_item(input int alloc_pct);
        if ($urandom_range(0, 99) < alloc_pct)
            send_item(lsm_pkg::OP_ALLOC, slot_t'($urandom_range(0, SLOTS - 1)));
        else if ($urandom_range(0, 99) < 85)
            send_item(lsm_pkg::OP_TOUCH, pick_handed_out_slot());
        else
            send_item(lsm_pkg::OP_TOUCH, slot_t'($urandom_range(0, SLOTS - 1)));
    endtask

    task automatic test_empty_pool_touches();
        send_item(lsm_pkg::OP_TOUCH, '0);
        send_item(lsm_pkg::OP_TOUCH, '1);
        send_item(lsm_pkg::OP_TOUCH, slot_t'(10'h155));
        send_item(lsm_pkg::OP_TOUCH, slot_t'(10'h2AA));
    endtask

    task automatic test_first_allocations();
        send_item(lsm_pkg::OP_ALLOC, '1);           // slot 0 links to itself
        send_item(lsm_pkg::OP_TOUCH, '0);           // newest: no change
        send_item(lsm_pkg::OP_TOUCH, slot_t'(1));   // not handed out yet
        send_item(lsm_pkg::OP_ALLOC, '0);
        send_item(lsm_pkg::OP_ALLOC, slot_t'(10'h2AA));
        send_item(lsm_pkg::OP_ALLOC, '0);
        send_item(lsm_pkg::OP_TOUCH, slot_t'(3));   // oldest
        send_item(lsm_pkg::OP_TOUCH, slot_t'(1));   // middle of the ring
        send_item(lsm_pkg::OP_TOUCH, slot_t'(1));   // now newest
        send_item(lsm_pkg::OP_TOUCH, slot_t'(4));
        send_item(lsm_pkg::OP_TOUCH, '1);
    endtask

    task automatic test_pause_for_results();
        repeat (8) send_random_item(60);
        wait_all_results();
        repeat (8) send_random_item(60);
    endtask

    task automatic test_fill_pool_random();
        while (ring_count < SLOTS) send_random_item(97);
    endtask

    task automatic test_full_pool_directed();
        send_item(lsm_pkg::OP_ALLOC, '0);           // oldest comes back as reused
        send_item(lsm_pkg::OP_ALLOC, '1);           // same victim, ring unchanged
        send_item(lsm_pkg::OP_TOUCH, ring_newer[ring_newest]);
        send_item(lsm_pkg::OP_ALLOC, '0);
        send_item(lsm_pkg::OP_TOUCH, '1);
        send_item(lsm_pkg::OP_TOUCH, '0);
        send_item(lsm_pkg::OP_TOUCH, ring_newest);
    endtask

    task automatic test_full_pool_random();
        repeat (40) send_random_item(40);
    endtask

    // Receiver: check each item taken, then pick the next ready level.
    always @(posedge aclk) begin
        slot_result_t want;
        lsm_pkg::lsm_flags_t flags;
        if (aresetn && m_tvalid && m_tready) begin
            flags = m_tuser;
            results_seen++;
            if (flags.reused) reuse_count++;
            if (flags.rejected) reject_count++;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got slot %0d reused %0b rejected %0b",
                         $time, m_tdata[SLOT_W-1:0], flags.reused, flags.rejected);
                mismatch_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[SLOT_W-1:0] !== want.slot) begin
                    $display("%0t: slot_out mismatch, expected %0d, got %0d",
                             $time, want.slot, m_tdata[SLOT_W-1:0]);
                    mismatch_count++;
                end
                if (flags.reused !== want.reused) begin
                    $display("%0t: reused mismatch, expected %0b, got %0b",
                             $time, want.reused, flags.reused);
                    mismatch_count++;
                end
                if (flags.rejected !== want.rejected) begin
                    $display("%0t: rejected mismatch, expected %0b, got %0b",
                             $time, want.rejected, flags.rejected);
                    mismatch_count++;
                end
            end
        end
        if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            case (cycle_count[9:8])
                2'd0: m_tready <= 1'b1;
                2'd1: m_tready <= ($urandom_range(0, 3) != 0);
                2'd2: begin
                    if ($urandom_range(0, 7) == 0) begin
                        m_tready <= 1'b0;
                        stall_left <= $urandom_range(0, 7);
                    end else begin
                        m_tready <= 1'b1;
                    end
                end
                default: m_tready <= cycle_count[0];
            endcase
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        burst_left = $urandom_range(0, 19);
        test_empty_pool_touches();
        test_first_allocations();
        test_pause_for_results();
        test_fill_pool_random();
        test_full_pool_directed();
        test_full_pool_random();
        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d items, checked %0d results; pool grew to %0d of %0d slots.",
                 items_sent, results_seen, ring_count, SLOTS);
        $display("Saw %0d reused allocations and %0d rejected touches.",
                 reuse_count, reject_count);
        if (mismatch_count == 0 && pending_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl
rtl/lsm_pkg.sv
rtl/lsm_link_ram.sv
rtl/lsm_seq.sv
rtl/lru_slot_list_manager.sv
sim/tb_lru_slot_list_manager.sv
